>>> hdl/ehbp_pkg.sv
// ----------------------------------------------------------------------------
// ehbp_pkg
// Shared constants for the ellipse hit test and boundary point block.
// ----------------------------------------------------------------------------
package ehbp_pkg;

  localparam int COORD_BITS_DEF = 16;

  localparam int CFG_INDEX_BITS = 2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_CORNER_A_X = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CORNER_A_Y = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CORNER_B_X = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CORNER_B_Y = 2'd3;

  localparam logic REQ_HIT      = 1'b0;
  localparam logic REQ_BOUNDARY = 1'b1;

endpackage

>>> hdl/ellipse_hit_and_boundary_point.sv
// ----------------------------------------------------------------------------
// ellipse_hit_and_boundary_point
// Point-in-ellipse test and ray-to-boundary point for an ellipse inscribed
// in a box held in four corner registers.
//
// Usage:
//   Input channel in_valid/in_stall carries one request per transfer:
//   req_type, point_x/y and toward_x/y. Output channel out_valid/out_stall
//   returns exactly one result per request, in order: inside_res, cross_x/y,
//   valid_res. The corner registers are written through cfg_we, cfg_index,
//   cfg_data while no request is in flight.
//   One request is accepted every cycle while in_stall is low. The depth
//   is set by the bit-per-stage square root (2*COORD_BITS stages) and the
//   bit-per-stage dividers (COORD_BITS-1 stages) that form the offsets.
//   Each stage advances when it is empty or the stage after it advances, so
//   a stall at the output holds the last result and lets bubbles upstream
//   close up; the input stalls only when every stage holds a request.
//   Reset (rst, synchronous) clears all stage valids and the corner
//   registers to zero.
// ----------------------------------------------------------------------------
module ellipse_hit_and_boundary_point #(
  parameter int COORD_BITS = ehbp_pkg::COORD_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [ehbp_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [COORD_BITS-1:0]                  cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   req_type,
  input  logic signed [COORD_BITS-1:0]           point_x,
  input  logic signed [COORD_BITS-1:0]           point_y,
  input  logic signed [COORD_BITS-1:0]           toward_x,
  input  logic signed [COORD_BITS-1:0]           toward_y,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   inside_res,
  output logic signed [COORD_BITS:0]             cross_x,
  output logic signed [COORD_BITS:0]             cross_y,
  output logic                                   valid_res
);

  localparam int N   = COORD_BITS;
  localparam int K   = N + 1;
  localparam int PW  = 2 * N + 1;
  localparam int SQW = 4 * N + 2;
  localparam int HW  = 4 * N + 3;
  localparam int SW  = 4 * N;
  localparam int RB  = 2 * N;
  localparam int QB  = N - 1;
  localparam int NW  = 3 * N + 1;
  localparam int NS  = 6 + RB + QB;
  localparam int ST_SQ = 5;
  localparam int ST_DV = 5 + RB;

  typedef struct packed {
    logic                req;
    logic                wnz;
    logic                hit;
    logic                negx;
    logic                negy;
    logic signed [N-1:0] basex;
    logic signed [N-1:0] basey;
  } carry_t;

  // corner registers
  logic signed [N-1:0] corner_a_x, corner_a_y, corner_b_x, corner_b_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      corner_a_x <= '0;
      corner_a_y <= '0;
      corner_b_x <= '0;
      corner_b_y <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ehbp_pkg::REG_CORNER_A_X: corner_a_x <= cfg_data;
        ehbp_pkg::REG_CORNER_A_Y: corner_a_y <= cfg_data;
        ehbp_pkg::REG_CORNER_B_X: corner_b_x <= cfg_data;
        ehbp_pkg::REG_CORNER_B_Y: corner_b_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage valids and advance chain
  logic [NS-1:0] v;
  logic [NS-1:0] rdy;
  carry_t        cr [NS];

  assign rdy[NS-1] = !v[NS-1] || !out_stall;
  for (genvar g = 0; g < NS - 1; g++) begin : g_rdy
    assign rdy[g] = !v[g] || rdy[g+1];
  end

  assign in_stall  = !rdy[0];
  assign out_valid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= in_valid;
      for (int i = 1; i < NS; i++) begin
        if (rdy[i]) v[i] <= v[i-1];
      end
    end
  end

  // stage 0: ordered box, half sizes, offsets from center, direction
  logic signed [N-1:0] xmin, xmax, ymin, ymax;
  logic [N:0]          wext, hext;
  logic [N-1:0]        w, h;
  logic [N-2:0]        ha, hb;
  logic [N+1:0]        u, vv, uneg, vneg;
  logic [N:0]          dx, dy, dxneg, dyneg, cenx, ceny;
  logic                tgt;
  carry_t              c0;

  always_comb begin
    xmin  = (corner_a_x < corner_b_x) ? corner_a_x : corner_b_x;
    xmax  = (corner_a_x < corner_b_x) ? corner_b_x : corner_a_x;
    ymin  = (corner_a_y < corner_b_y) ? corner_a_y : corner_b_y;
    ymax  = (corner_a_y < corner_b_y) ? corner_b_y : corner_a_y;
    wext  = {xmax[N-1], xmax} - {xmin[N-1], xmin};
    hext  = {ymax[N-1], ymax} - {ymin[N-1], ymin};
    w     = wext[N-1:0];
    h     = hext[N-1:0];
    ha    = w[N-1:1];
    hb    = h[N-1:1];
    u     = {point_x[N-1], point_x, 1'b0} - {{2{xmin[N-1]}}, xmin}
            - {{2{xmax[N-1]}}, xmax};
    vv    = {point_y[N-1], point_y, 1'b0} - {{2{ymin[N-1]}}, ymin}
            - {{2{ymax[N-1]}}, ymax};
    uneg  = -u;
    vneg  = -vv;
    dx    = {toward_x[N-1], toward_x} - {point_x[N-1], point_x};
    dy    = {toward_y[N-1], toward_y} - {point_y[N-1], point_y};
    dxneg = -dx;
    dyneg = -dy;
    cenx  = {xmax[N-1], xmax} - {2'b00, ha};
    ceny  = {ymax[N-1], ymax} - {2'b00, hb};
    tgt   = ({toward_x[N-1], toward_x} == cenx) && ({toward_y[N-1], toward_y} == ceny);
    c0.req    = req_type;
    c0.wnz    = (w != '0) && (h != '0);
    c0.hit    = 1'b0;
    c0.negx   = dx[N] ^ tgt;
    c0.negy   = dy[N] ^ tgt;
    c0.basex  = tgt ? toward_x : point_x;
    c0.basey  = tgt ? toward_y : point_y;
  end

  logic [N:0]   s0_ux, s0_vy;
  logic [N-1:0] s0_w, s0_h, s0_mx, s0_my;
  logic [N-2:0] s0_a, s0_b;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s0_ux <= u[N+1] ? uneg[N:0] : u[N:0];
      s0_vy <= vv[N+1] ? vneg[N:0] : vv[N:0];
      s0_w  <= w;
      s0_h  <= h;
      s0_a  <= ha;
      s0_b  <= hb;
      s0_mx <= dx[N] ? dxneg[N-1:0] : dx[N-1:0];
      s0_my <= dy[N] ? dyneg[N-1:0] : dy[N-1:0];
    end
  end

  // stage 1: first products
  logic [PW-1:0]    s1_prod [5];
  logic [2*N-3:0]   s1_ab;
  logic [N-1:0]     s1_mx, s1_my;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_prod[0] <= s0_ux * s0_h;
      s1_prod[1] <= s0_vy * s0_w;
      s1_prod[2] <= PW'(s0_w * s0_h);
      s1_prod[3] <= PW'(s0_b * s0_mx);
      s1_prod[4] <= PW'(s0_a * s0_my);
      s1_ab      <= s0_a * s0_b;
      s1_mx      <= s0_mx;
      s1_my      <= s0_my;
    end
  end

  // stage 2: partial products of the squares and numerators
  logic [2*N-1:0] s2_hh [5];
  logic [2*N:0]   s2_hl [5];
  logic [2*K-1:0] s2_ll [5];
  logic [2*N-1:0] s2_nxh, s2_nyh;
  logic [2*N:0]   s2_nxl, s2_nyl;
  logic [PW-1:0]  abp;

  assign abp = {3'b000, s1_ab};

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      for (int e = 0; e < 5; e++) begin
        s2_hh[e] <= s1_prod[e][PW-1:K] * s1_prod[e][PW-1:K];
        s2_hl[e] <= s1_prod[e][PW-1:K] * s1_prod[e][K-1:0];
        s2_ll[e] <= s1_prod[e][K-1:0] * s1_prod[e][K-1:0];
      end
      s2_nxh <= abp[PW-1:K] * s1_mx;
      s2_nxl <= abp[K-1:0] * s1_mx;
      s2_nyh <= abp[PW-1:K] * s1_my;
      s2_nyl <= abp[K-1:0] * s1_my;
    end
  end

  // stage 3: assemble squares and numerators
  logic [SQW-1:0] s3_sq [5];
  logic [NW-1:0]  s3_nx, s3_ny;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      for (int e = 0; e < 5; e++) begin
        s3_sq[e] <= (SQW'(s2_hh[e]) << (2 * K)) + (SQW'(s2_hl[e]) << (K + 1))
                    + SQW'(s2_ll[e]);
      end
      s3_nx <= (NW'(s2_nxh) << K) + NW'(s2_nxl);
      s3_ny <= (NW'(s2_nyh) << K) + NW'(s2_nyl);
    end
  end

  // stage 4: hit compare and root radicand
  logic [HW-1:0]  lhs;
  logic [SQW-1:0] ssum;
  carry_t         c4;

  always_comb begin
    lhs    = HW'(s3_sq[0]) + HW'(s3_sq[1]);
    ssum   = s3_sq[3] + s3_sq[4];
    c4     = cr[3];
    c4.hit = (cr[3].req == ehbp_pkg::REQ_HIT) && cr[3].wnz && (lhs <= HW'(s3_sq[2]));
  end

  logic [SW-1:0] s4_x;
  logic [NW-1:0] s4_nx, s4_ny;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s4_x  <= ssum[SW-1:0];
      s4_nx <= s3_nx;
      s4_ny <= s3_ny;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) cr[0] <= c0;
    for (int i = 1; i < NS; i++) begin
      if (rdy[i]) cr[i] <= (i == 4) ? c4 : cr[i-1];
    end
  end

  // square root, one result bit per stage
  logic [SW-1:0] sqx [RB];
  logic [SW-1:0] sqr [RB];
  logic [NW-1:0] sqnx [RB];
  logic [NW-1:0] sqny [RB];

  for (genvar j = 0; j < RB; j++) begin : g_sqrt
    localparam int KB = RB - 1 - j;
    localparam logic [SW-1:0] BITV = SW'(1) << (2 * KB);
    logic [SW-1:0] xin, rin, trial;
    logic [NW-1:0] nxin, nyin;

    if (j == 0) begin : g_first
      assign xin  = s4_x;
      assign rin  = '0;
      assign nxin = s4_nx;
      assign nyin = s4_ny;
    end else begin : g_next
      assign xin  = sqx[j-1];
      assign rin  = sqr[j-1];
      assign nxin = sqnx[j-1];
      assign nyin = sqny[j-1];
    end

    assign trial = rin + BITV;

    always_ff @(posedge clk) begin
      if (rdy[ST_SQ+j]) begin
        if (xin >= trial) begin
          sqx[j] <= xin - trial;
          sqr[j] <= (rin >> 1) + BITV;
        end else begin
          sqx[j] <= xin;
          sqr[j] <= rin >> 1;
        end
        sqnx[j] <= nxin;
        sqny[j] <= nyin;
      end
    end
  end

  // offset dividers, one quotient bit per stage
  logic [NW-1:0] dvx [QB];
  logic [NW-1:0] dvy [QB];
  logic [QB-1:0] dqx [QB];
  logic [QB-1:0] dqy [QB];
  logic [RB-1:0] dvr [QB];

  for (genvar j = 0; j < QB; j++) begin : g_div
    localparam int IB = QB - 1 - j;
    logic [NW-1:0] nxin, nyin, dvs;
    logic [QB-1:0] qxin, qyin;
    logic [RB-1:0] root;
    logic          bx, by;

    if (j == 0) begin : g_first
      assign nxin = sqnx[RB-1];
      assign nyin = sqny[RB-1];
      assign qxin = '0;
      assign qyin = '0;
      assign root = sqr[RB-1][RB-1:0];
    end else begin : g_next
      assign nxin = dvx[j-1];
      assign nyin = dvy[j-1];
      assign qxin = dqx[j-1];
      assign qyin = dqy[j-1];
      assign root = dvr[j-1];
    end

    assign dvs = NW'(root) << IB;
    assign bx  = nxin >= dvs;
    assign by  = nyin >= dvs;

    always_ff @(posedge clk) begin
      if (rdy[ST_DV+j]) begin
        dvx[j] <= bx ? nxin - dvs : nxin;
        dvy[j] <= by ? nyin - dvs : nyin;
        dqx[j] <= {qxin[QB-2:0], bx};
        dqy[j] <= {qyin[QB-2:0], by};
        dvr[j] <= root;
      end
    end
  end

  // final stage: apply offsets
  logic [N:0] offx, offy, basex, basey, sumx, sumy;
  logic       ok;
  carry_t     cf;

  always_comb begin
    cf    = cr[NS-2];
    offx  = {2'b00, dqx[QB-1]};
    offy  = {2'b00, dqy[QB-1]};
    basex = {cf.basex[N-1], cf.basex};
    basey = {cf.basey[N-1], cf.basey};
    sumx  = cf.negx ? basex - offx : basex + offx;
    sumy  = cf.negy ? basey - offy : basey + offy;
    ok    = (cf.req == ehbp_pkg::REQ_BOUNDARY) && (dvr[QB-1] != '0);
  end

  always_ff @(posedge clk) begin
    if (rdy[NS-1]) begin
      inside_res <= cf.hit;
      valid_res  <= ok;
      cross_x    <= ok ? sumx : '0;
      cross_y    <= ok ? sumy : '0;
    end
  end

endmodule

>>> sim/tb_ellipse_hit_and_boundary_point.sv
// ----------------------------------------------------------------------------
// tb_ellipse_hit_and_boundary_point
// Self-checking bench for the ellipse hit test and boundary point block.
// Hit and boundary requests are driven under several box settings, from a
// zero-area box to full-range corners. Each result is compared against an
// in-bench predictor, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_ellipse_hit_and_boundary_point;

  localparam int CB = 16;
  localparam int LIMIT = 600000;
  localparam int LATENCY = 3 * CB + 5;

  typedef struct packed {
    logic          hit;
    logic [CB:0]   cx;
    logic [CB:0]   cy;
    logic          vld;
  } ellipse_res_t;

  class ellipse_scoreboard;
    logic signed [CB-1:0] corner[4];
    ellipse_res_t pending[$];
    int errors;
    int hits_seen;
    int bounds_seen;

    function new();
      foreach (corner[i]) corner[i] = '0;
      errors = 0;
      hits_seen = 0;
      bounds_seen = 0;
    endfunction

    function void box(output longint xmin, xmax, ymin, ymax);
      longint ax, ay, bx, by;
      ax = corner[ehbp_pkg::REG_CORNER_A_X];
      ay = corner[ehbp_pkg::REG_CORNER_A_Y];
      bx = corner[ehbp_pkg::REG_CORNER_B_X];
      by = corner[ehbp_pkg::REG_CORNER_B_Y];
      xmin = ax < bx ? ax : bx;
      xmax = ax < bx ? bx : ax;
      ymin = ay < by ? ay : by;
      ymax = ay < by ? by : ay;
    endfunction

    function void note(logic rt, logic signed [CB-1:0] px, py, tx, ty);
      ellipse_res_t e;
      longint xmin, xmax, ymin, ymax, u, v, dx, dy, offx, offy, cxl, cyl;
      logic [127:0] uu, vv, ww, hh, aa, bb, mx, my, s, root, t;
      box(xmin, xmax, ymin, ymax);
      e = '0;
      ww = 128'(xmax - xmin);
      hh = 128'(ymax - ymin);
      if (rt == ehbp_pkg::REQ_HIT) begin
        hits_seen++;
        u = 2 * longint'(px) - xmin - xmax;
        v = 2 * longint'(py) - ymin - ymax;
        uu = 128'(u < 0 ? -u : u);
        vv = 128'(v < 0 ? -v : v);
        if (ww != 0 && hh != 0 && uu * uu * hh * hh + vv * vv * ww * ww <= ww * ww * hh * hh)
          e.hit = 1'b1;
      end else begin
        bounds_seen++;
        aa = ww >> 1;
        bb = hh >> 1;
        dx = longint'(tx) - longint'(px);
        dy = longint'(ty) - longint'(py);
        mx = 128'(dx < 0 ? -dx : dx);
        my = 128'(dy < 0 ? -dy : dy);
        s = bb * bb * mx * mx + aa * aa * my * my;
        root = '0;
        for (int bit_i = 63; bit_i >= 0; bit_i--) begin
          t = root | (128'd1 << bit_i);
          if (t * t <= s) root = t;
        end
        if ((dx != 0 || dy != 0) && root != 0) begin
          offx = longint'((aa * bb * mx) / root);
          offy = longint'((aa * bb * my) / root);
          if (dx < 0) offx = -offx;
          if (dy < 0) offy = -offy;
          if (longint'(tx) == xmax - longint'(aa) && longint'(ty) == ymax - longint'(bb)) begin
            cxl = longint'(tx) - offx;
            cyl = longint'(ty) - offy;
          end else begin
            cxl = longint'(px) + offx;
            cyl = longint'(py) + offy;
          end
          e.cx = cxl[CB:0];
          e.cy = cyl[CB:0];
          e.vld = 1'b1;
        end
      end
      pending.push_back(e);
    endfunction

    function void check(ellipse_res_t got);
      ellipse_res_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.hit !== e.hit) begin
        $display("%0t: inside_res exp %0d got %0d", $time, e.hit, got.hit);
        errors++;
      end
      if (got.cx !== e.cx) begin
        $display("%0t: cross_x exp %0d got %0d", $time, $signed(e.cx), $signed(got.cx));
        errors++;
      end
      if (got.cy !== e.cy) begin
        $display("%0t: cross_y exp %0d got %0d", $time, $signed(e.cy), $signed(got.cy));
        errors++;
      end
      if (got.vld !== e.vld) begin
        $display("%0t: valid_res exp %0d got %0d", $time, e.vld, got.vld);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [ehbp_pkg::CFG_INDEX_BITS-1:0] cfg_index = ehbp_pkg::REG_CORNER_A_X;
  logic [CB-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic req_type = ehbp_pkg::REQ_HIT;
  logic signed [CB-1:0] point_x = '0, point_y = '0, toward_x = '0, toward_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic inside_res, valid_res;
  logic signed [CB:0] cross_x, cross_y;

  ellipse_scoreboard sb = new();
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int unsigned cycles = 0;

  ellipse_hit_and_boundary_point #(.COORD_BITS(CB)) u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .point_x(point_x), .point_y(point_y),
    .toward_x(toward_x), .toward_y(toward_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .inside_res(inside_res), .cross_x(cross_x), .cross_y(cross_y),
    .valid_res(valid_res)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
    if (!rst && out_valid && !out_stall)
      sb.check({inside_res, cross_x, cross_y, valid_res});
  end

  always @(negedge clk)
    out_stall <= ($urandom_range(99) < rx_idle_pct);

  task automatic write_reg(logic [ehbp_pkg::CFG_INDEX_BITS-1:0] idx,
                           logic signed [CB-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.corner[idx] = val;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic set_box(logic signed [CB-1:0] ax, ay, bx, by);
    drain();
    write_reg(ehbp_pkg::REG_CORNER_A_X, ax);
    write_reg(ehbp_pkg::REG_CORNER_A_Y, ay);
    write_reg(ehbp_pkg::REG_CORNER_B_X, bx);
    write_reg(ehbp_pkg::REG_CORNER_B_Y, by);
  endtask

  task automatic send(logic rt, logic signed [CB-1:0] px, py, tx, ty);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rt;
    point_x <= px;
    point_y <= py;
    toward_x <= tx;
    toward_y <= ty;
    do @(posedge clk); while (in_stall);
    sb.note(rt, px, py, tx, ty);
    @(negedge clk);
  endtask

  function automatic logic signed [CB-1:0] near(longint lo, longint hi);
    longint m, r;
    m = (hi - lo) / 4 + 3;
    r = longint'($urandom_range(32'(hi - lo + 2 * m))) + lo - m;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[CB-1:0];
  endfunction

  task automatic random_items(int n);
    longint xmin, xmax, ymin, ymax, cx, cy;
    logic signed [CB-1:0] px, py, tx, ty;
    int pick;
    for (int i = 0; i < n; i++) begin
      sb.box(xmin, xmax, ymin, ymax);
      cx = xmax - (xmax - xmin) / 2;
      cy = ymax - (ymax - ymin) / 2;
      pick = $urandom_range(99);
      if (pick < 15) begin
        px = CB'($urandom); py = CB'($urandom); tx = CB'($urandom); ty = CB'($urandom);
      end else begin
        px = near(xmin, xmax); py = near(ymin, ymax);
        tx = near(xmin, xmax); ty = near(ymin, ymax);
      end
      if (pick >= 15 && pick < 30) begin
        tx = cx[CB-1:0];
        ty = cy[CB-1:0];
      end else if (pick >= 30 && pick < 35) begin
        tx = px;
        ty = py;
      end
      send(1'($urandom_range(1)), px, py, tx, ty);
      if (i == n / 2) begin
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
      end
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // zero-area box straight after reset
    tx_idle_pct = 21; rx_idle_pct = 58;
    send(ehbp_pkg::REQ_HIT, 0, 0, 0, 0);
    send(ehbp_pkg::REQ_BOUNDARY, 0, 0, 5, 7);
    send(ehbp_pkg::REQ_BOUNDARY, 3, 3, 3, 3);
    in_valid <= 1'b0;

    set_box(100, 60, -100, -60);
    send(ehbp_pkg::REQ_HIT, 0, 0, 0, 0);
    send(ehbp_pkg::REQ_HIT, 100, 0, 0, 0);
    send(ehbp_pkg::REQ_HIT, 101, 0, 0, 0);
    send(ehbp_pkg::REQ_HIT, 0, -60, 0, 0);
    send(ehbp_pkg::REQ_HIT, 70, 43, 0, 0);
    send(ehbp_pkg::REQ_HIT, -32768, -32768, 0, 0);
    send(ehbp_pkg::REQ_HIT, 32767, 32767, 0, 0);
    send(ehbp_pkg::REQ_BOUNDARY, 10, 10, 10, 10);
    send(ehbp_pkg::REQ_BOUNDARY, 30, 20, 0, 0);
    send(ehbp_pkg::REQ_BOUNDARY, 0, 0, 50, 0);
    send(ehbp_pkg::REQ_BOUNDARY, 0, 0, 0, -50);
    send(ehbp_pkg::REQ_BOUNDARY, -32768, -32768, 32767, 32767);
    send(ehbp_pkg::REQ_BOUNDARY, 32767, 32767, -32768, -32768);
    send(ehbp_pkg::REQ_BOUNDARY, 32767, -32768, -32768, 32767);
    send(ehbp_pkg::REQ_BOUNDARY, 5, -7, 40, 33);
    in_valid <= 1'b0;
    random_items(180);

    set_box(-32768, -32768, 32767, 32767);
    random_items(200);
    set_box(32767, 32767, -32768, -32768);
    random_items(200);

    tx_idle_pct = 58; rx_idle_pct = 21;
    set_box(7, -3, 7, 40);
    random_items(150);
    set_box(-5, 11, 3, 11);
    random_items(150);
    set_box(-1234, 501, 77, -6);
    random_items(200);

    tx_idle_pct = 0; rx_idle_pct = 0;
    set_box(2, 3, 1, 0);
    random_items(150);
    set_box(CB'($urandom), CB'($urandom), CB'($urandom), CB'($urandom));
    random_items(200);
    set_box(-32768, 0, 32767, 1);
    random_items(150);

    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 20) @(negedge clk);
    $display("Covered %0d hit tests and %0d boundary requests over ten box settings.",
             sb.hits_seen, sb.bounds_seen);
    $display("Both channels ran with and without random idling; mismatches: %0d.",
             sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
